// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the rational arithmetic core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the next cycle.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Beat types and operation codes shared by the rational arithmetic core.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned WordBits = 64;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] a_num;
    logic        [30:0] a_den;
    logic signed [31:0] b_num;
    logic        [30:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic        [62:0] res_den;
    logic               zero_den_error;
  } rsp_t;

endpackage

// File: rtl/core/rau_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, modulo 2^64.
// ----------------------------------------------------------------------------
module rau_mul import rau_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] mcand_i,
  input  logic [W-1:0]        mplier_i,
  output logic                done_o,
  output logic [WordBits-1:0] prod_o
);

  localparam int unsigned CntBits = (W > 1) ? $clog2(W) : 1;
  localparam logic [CntBits-1:0] LastCnt = CntBits'(W - 1);

  logic                run_q, run_d, done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [W-1:0]        mp_q, mp_d;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      acc_d = '0;
      mc_d  = mcand_i;
      mp_d  = mplier_i;
    end else if (run_q) begin
      // The top multiplier bit carries negative weight.
      if (mp_q[0]) begin
        acc_d = (cnt_q == LastCnt) ? acc_q - mc_q : acc_q + mc_q;
      end
      mc_d  = {mc_q[WordBits-2:0], 1'b0};
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/core/rau_gcd.sv
// ----------------------------------------------------------------------------
// Binary GCD
// Stein's algorithm, one shift or one subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] x_i,
  input  logic [WordBits-1:0] y_i,
  output logic                done_o,
  output logic [WordBits-1:0] g_o
);

  typedef enum logic [4:0] {
    G_IDLE = 5'b00001,
    G_COM  = 5'b00010,
    G_X    = 5'b00100,
    G_Y    = 5'b01000,
    G_SH   = 5'b10000
  } gstate_e;

  gstate_e             state_q, state_d;
  logic                done_q, done_d;
  logic [5:0]          sh_q, sh_d;
  logic [WordBits-1:0] x_q, x_d, y_q, y_d;
  logic [WordBits:0]   diff;

  assign diff = {1'b0, y_q} - {1'b0, x_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    sh_d    = sh_q;
    x_d     = x_q;
    y_d     = y_q;
    unique case (state_q)
      G_IDLE: begin
        if (start_i) begin
          x_d     = x_i;
          y_d     = y_i;
          sh_d    = '0;
          state_d = G_COM;
        end
      end
      G_COM: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d  = x_q >> 1;
          y_d  = y_q >> 1;
          sh_d = sh_q + 1'b1;
        end else begin
          state_d = G_X;
        end
      end
      G_X: begin
        if (!x_q[0]) x_d = x_q >> 1;
        else state_d = G_Y;
      end
      G_Y: begin
        if (y_q == '0) begin
          state_d = G_SH;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (diff[WordBits]) begin
          // x is larger: swap, then subtract.
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = diff[WordBits-1:0];
        end
      end
      G_SH: begin
        if (sh_q != '0) begin
          x_d  = {x_q[WordBits-2:0], 1'b0};
          sh_d = sh_q - 1'b1;
        end else begin
          done_d  = 1'b1;
          state_d = G_IDLE;
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
      sh_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sh_q    <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign done_o = done_q;
  assign g_o    = x_q;

endmodule

// File: rtl/core/rau_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] dividend_i,
  input  logic [WordBits-1:0] divisor_i,
  output logic                done_o,
  output logic [WordBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(WordBits);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(WordBits - 1);

  logic                run_q, run_d, done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [WordBits-1:0] trial;
  logic [WordBits:0]   sub;

  // The remainder stays below the divisor, which never exceeds 2^63.
  assign trial = {rem_q[WordBits-2:0], quo_q[WordBits-1]};
  assign sub   = {1'b0, trial} - {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (run_q) begin
      rem_d = sub[WordBits] ? trial : sub[WordBits-1:0];
      quo_d = {quo_q[WordBits-2:0], ~sub[WordBits]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/core/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; the unit then
// works on it alone and raises valid_o for exactly one cycle with the reduced
// fraction, which the receiver must take in that cycle since it cannot stall.
// For one beat, the three cross products share one bit-serial multiplier, the
// reduction runs one shift or subtract per cycle, and both divisions by the GCD
// share one restoring divider that yields a quotient bit per cycle. A zero raw
// denominator or numerator skips the reduction and returns 0/1 early.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned W = OPERAND_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_SUM   = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_ABS   = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  // Numerators are read as W-bit two's complement, denominators as W-1 bits.
  function automatic logic [WordBits-1:0] sext_num(input logic [31:0] v);
    return {{(WordBits - W){v[W-1]}}, v[W-1:0]};
  endfunction

  function automatic logic [WordBits-1:0] zext_den(input logic [30:0] v);
    return {{(WordBits - W + 1){1'b0}}, v[W-2:0]};
  endfunction

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  rsp_t                rsp_q, rsp_d;
  logic                valid_q, valid_d;
  logic [1:0]          step_q, step_d;
  logic                mul_go_q, mul_go_d, gcd_go_q, gcd_go_d, div_go_q, div_go_d;
  logic                neg_q, neg_d;
  logic [WordBits-1:0] p0_q, p0_d, p1_q, p1_d, n_q, n_d, d_q, d_d, g_q, g_d;
  logic [WordBits-1:0] qn_q, qn_d;

  logic [WordBits-1:0] an, ad, bn, bd;
  logic [WordBits-1:0] mcand, mplier64;
  logic                mul_done, gcd_done, div_done;
  logic [WordBits-1:0] mul_prod, gcd_g, div_quot, div_dividend;
  logic                two_term;

  assign an = sext_num(req_q.a_num);
  assign ad = zext_den(req_q.a_den);
  assign bn = sext_num(req_q.b_num);
  assign bd = zext_den(req_q.b_den);
  assign two_term = (req_q.mode == MODE_ADD) || (req_q.mode == MODE_SUB);

  // Step 0 and 1 form the numerator terms, step 2 the denominator.
  always_comb begin
    mcand    = '0;
    mplier64 = '0;
    unique case (step_q)
      2'd0: begin
        mcand    = an;
        mplier64 = (req_q.mode == MODE_MUL) ? bn : bd;
      end
      2'd1: begin
        mcand    = two_term ? bn : '0;
        mplier64 = ad;
      end
      default: begin
        mcand    = ad;
        mplier64 = (req_q.mode == MODE_DIV) ? bn : bd;
      end
    endcase
  end

  assign div_dividend = (state_q == S_DIVN) ? n_q : d_q;

  rau_mul #(.W(W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go_q),
    .mcand_i  (mcand),
    .mplier_i (mplier64[W-1:0]),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_go_q),
    .x_i     (n_q),
    .y_i     (d_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_dividend),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    rsp_d    = rsp_q;
    valid_d  = 1'b0;
    step_d   = step_q;
    mul_go_d = 1'b0;
    gcd_go_d = 1'b0;
    div_go_d = 1'b0;
    neg_d    = neg_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    n_d      = n_q;
    d_d      = d_q;
    g_d      = g_q;
    qn_d     = qn_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d    = req_i;
          step_d   = 2'd0;
          mul_go_d = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          unique case (step_q)
            2'd0:    p0_d = mul_prod;
            2'd1:    p1_d = mul_prod;
            default: d_d  = mul_prod;
          endcase
          if (step_q == 2'd2) begin
            state_d = S_SUM;
          end else begin
            step_d   = step_q + 2'd1;
            mul_go_d = 1'b1;
          end
        end
      end
      S_SUM: begin
        n_d     = (req_q.mode == MODE_SUB) ? p0_q - p1_q : p0_q + p1_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        // A zero denominator wins over a zero numerator, so 0/0 is an error.
        if (d_q == '0 || n_q == '0) begin
          rsp_d.res_num        = '0;
          rsp_d.res_den        = 63'd1;
          rsp_d.zero_den_error = (d_q == '0);
          valid_d              = 1'b1;
          state_d              = S_IDLE;
        end else begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        neg_d    = n_q[WordBits-1] ^ d_q[WordBits-1];
        n_d      = n_q[WordBits-1] ? '0 - n_q : n_q;
        d_d      = d_q[WordBits-1] ? '0 - d_q : d_q;
        gcd_go_d = 1'b1;
        state_d  = S_GCD;
      end
      S_GCD: begin
        if (gcd_done) begin
          g_d      = gcd_g;
          div_go_d = 1'b1;
          state_d  = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          qn_d     = div_quot;
          div_go_d = 1'b1;
          state_d  = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          d_d     = div_quot;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        rsp_d.res_num        = neg_q ? '0 - qn_q : qn_q;
        rsp_d.res_den        = d_q[WordBits-2:0];
        rsp_d.zero_den_error = 1'b0;
        valid_d              = 1'b1;
        state_d              = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      step_q   <= 2'd0;
      mul_go_q <= 1'b0;
      gcd_go_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      step_q   <= step_d;
      mul_go_q <= mul_go_d;
      gcd_go_q <= gcd_go_d;
      div_go_q <= div_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    neg_q <= neg_d;
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    n_q   <= n_d;
    d_q   <= d_d;
    g_q   <= g_d;
    qn_q  <= qn_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // A result beat is emitted only after the unit has gone back to idle.
  `RAU_ASSERT(a_valid_idle, valid_o |-> !busy, "result beat while busy")
  // An accepted request keeps the unit busy in the next cycle.
  `RAU_ASSERT_NEXT(a_start_busy, start && !busy, busy && !valid_o, "request not taken")
  // An error result is always the fraction 0/1.
  `RAU_ASSERT(a_err_zero, valid_o && rsp_o.zero_den_error |->
    (rsp_o.res_num == '0) && (rsp_o.res_den == 63'd1), "error result not 0/1")
  // The sub-units are only launched while a request is in flight.
  `RAU_ASSERT(a_go_busy, (mul_go_q || gcd_go_q || div_go_q) |-> busy, "unit launched idle")

endmodule
